// File: src/jbee_pkg.sv
// Shared types, constants and a helper function of the JPEG block entropy encoder.
package jbee_pkg;

   localparam int COEFS_PER_BLOCK = 64;
   localparam int TABLE_ENTRIES   = 188;
   localparam int TABLE_W         = 21;
   localparam int TABLE_AW        = 8;
   localparam int CODE_W          = 16;
   localparam int LEN_W           = 5;
   localparam int VLI_W           = 11;
   localparam int SIZE_W          = 4;
   localparam int AC_BASE         = 12;
   localparam int AC_STRIDE       = 11;
   localparam int ZRL_INDEX       = AC_BASE + 15 * AC_STRIDE;
   localparam int EOB_INDEX       = AC_BASE;
   localparam int MAX_RESULTS     = 16;
   localparam int OUT_DEPTH       = 4;

   localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;
   localparam logic [7:0] STUFF_BYTE    = 8'h00;
   localparam logic signed [10:0] COEF_MIN = 11'sh400;

   typedef enum logic [1:0] {
      REQ_COEF  = 2'd0,
      REQ_TABLE = 2'd1,
      REQ_FLUSH = 2'd2
   } req_kind_type;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_READ  = 6'b000010,
      S_CODE  = 6'b000100,
      S_VLI   = 6'b001000,
      S_DRAIN = 6'b010000,
      S_END   = 6'b100000
   } enc_state_type;

   typedef struct packed {
      logic                wr_en;
      logic [TABLE_AW-1:0] wr_addr;
      logic [TABLE_W-1:0]  wr_data;
      logic                rd_en;
      logic [TABLE_AW-1:0] rd_addr;
   } tbl_access_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } byte_push_type;

   // Number of significant bits of a magnitude (the JPEG size category).
   function automatic logic [SIZE_W-1:0] size_of(input logic [VLI_W-1:0] mag);
      logic [SIZE_W-1:0] s;
      s = '0;
      for (int i = 0; i < VLI_W; i++) begin
         if (mag[i]) s = SIZE_W'(i + 1);
      end
      return s;
   endfunction

endpackage

// File: src/jbee_if.sv
// Valid/ready channel interfaces for the request and response sides.
interface jbee_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic signed [10:0] coefficient;
   logic signed [10:0] prev_dc;
   logic [7:0]         table_index;
   logic [15:0]        code_bits;
   logic [4:0]         code_length;

   modport source (output valid, req_type, coefficient, prev_dc, table_index, code_bits,
                   code_length, input ready);
   modport sink (input valid, req_type, coefficient, prev_dc, table_index, code_bits,
                 code_length, output ready);
endinterface

interface jbee_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, out_byte, last_of_run, input ready);
   modport sink (input valid, out_byte, last_of_run, output ready);
endinterface

// File: src/jbee_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module jbee_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 188
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/jbee_out_fifo.sv
// Small register queue that holds coded bytes until the response side takes them.
module jbee_out_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  jbee_pkg::byte_push_type push,
   output logic                  push_space,
   jbee_rsp_if.source            rsp
);

   localparam int PTR_W = $clog2(jbee_pkg::OUT_DEPTH);
   localparam int CNT_W = $clog2(jbee_pkg::OUT_DEPTH + 1);

   logic [8:0]       data_ff [jbee_pkg::OUT_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_space = count_ff != CNT_W'(jbee_pkg::OUT_DEPTH);
   assign do_push    = push.valid && push_space;
   assign do_pop     = rsp.valid && rsp.ready;

   assign rsp.valid       = count_ff != '0;
   assign rsp.out_byte    = data_ff[rd_ptr_ff][8:1];
   assign rsp.last_of_run = data_ff[rd_ptr_ff][0];

   always_comb begin
      wr_ptr_in = do_push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = CNT_W'(count_ff + 1'b1);
      if (!do_push && do_pop) count_in = CNT_W'(count_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) data_ff[wr_ptr_ff] <= {push.data, push.last};
   end

endmodule

// File: src/jbee_engine.sv
// Coding sequencer: table reads, bit packing, byte stuffing and result framing.
module jbee_engine #(
   parameter int MAX_CODE_LEN = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   jbee_req_if.sink                              req,
   output jbee_pkg::tbl_access_type              tbl,
   input  logic [jbee_pkg::TABLE_W-1:0]          tbl_rd_data,
   output jbee_pkg::byte_push_type               push,
   input  logic                                  push_space
);

   localparam int MERGE_MAX = (MAX_CODE_LEN > jbee_pkg::VLI_W) ? MAX_CODE_LEN
                                                                : jbee_pkg::VLI_W;
   localparam int ACC_W     = 7 + MERGE_MAX;
   localparam int CNT_W     = $clog2(ACC_W + 1);
   localparam int AW        = jbee_pkg::TABLE_AW;
   localparam int RES_W     = $clog2(jbee_pkg::MAX_RESULTS + 1);

   jbee_pkg::enc_state_type state_ff, state_in;

   logic [5:0]                   pos_ff, pos_in;
   logic [5:0]                   zr_ff, zr_in;
   logic [ACC_W-1:0]             acc_ff, acc_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         stuff_ff, stuff_in;
   logic [1:0]                   zrl_cnt_ff, zrl_cnt_in;
   logic                         main_pend_ff, main_pend_in;
   logic                         vli_pend_ff, vli_pend_in;
   logic                         eob_pend_ff, eob_pend_in;
   logic [AW-1:0]                main_idx_ff, main_idx_in;
   logic [jbee_pkg::VLI_W-1:0]   vli_bits_ff, vli_bits_in;
   logic [jbee_pkg::SIZE_W-1:0]  vli_size_ff, vli_size_in;
   logic [AW-1:0]                rd_addr_ff, rd_addr_in;
   logic [RES_W-1:0]             bytes_ff, bytes_in;
   logic [7:0]                   hold_ff, hold_in;
   logic                         hold_valid_ff, hold_valid_in;

   logic                         accept;
   logic                         last_pos;
   logic signed [10:0]           coef, prev, coef_sat;
   logic signed [11:0]           val12, vli12;
   logic [11:0]                  mag12;
   logic [jbee_pkg::SIZE_W-1:0]  sz;
   logic [AW-1:0]                ac_idx;
   logic [5:0]                   zr_inc;

   logic [jbee_pkg::LEN_W-1:0]   merge_len;
   logic [jbee_pkg::CODE_W-1:0]  merge_bits;
   logic [jbee_pkg::CODE_W:0]    len_mask;
   logic [ACC_W-1:0]             merged;
   logic [CNT_W-1:0]             cnt_merge;

   logic                         have_byte;
   logic [7:0]                   extracted;
   logic [7:0]                   byte_val;
   logic                         drop;
   logic                         emit_go;
   logic [jbee_pkg::LEN_W-1:0]   len_sat;

   assign accept    = req.valid && req.ready;
   assign req.ready = state_ff == jbee_pkg::S_IDLE;
   assign last_pos  = pos_ff == 6'(jbee_pkg::COEFS_PER_BLOCK - 1);

   // Value to code: DC difference at block start, otherwise the clamped AC value.
   always_comb begin
      coef     = req.coefficient;
      prev     = req.prev_dc;
      coef_sat = (coef == jbee_pkg::COEF_MIN) ? jbee_pkg::COEF_MIN + 11'sd1 : coef;
      if (pos_ff == '0) val12 = {coef[10], coef} - {prev[10], prev};
      else              val12 = {coef_sat[10], coef_sat};
      mag12  = val12[11] ? 12'(-val12) : 12'(val12);
      vli12  = val12[11] ? val12 - 12'sd1 : val12;
      sz     = jbee_pkg::size_of(mag12[jbee_pkg::VLI_W-1:0]);
      ac_idx = AW'(jbee_pkg::AC_BASE) + AW'(zr_ff[3:0]) * AW'(jbee_pkg::AC_STRIDE) + AW'(sz);
      zr_inc = 6'(zr_ff + 6'd1);
   end

   // Append a right-aligned field of merge_len bits under the pending bits.
   always_comb begin
      if (state_ff == jbee_pkg::S_VLI) begin
         merge_len  = jbee_pkg::LEN_W'(vli_size_ff);
         merge_bits = jbee_pkg::CODE_W'(vli_bits_ff);
      end else begin
         merge_len  = tbl_rd_data[jbee_pkg::TABLE_W-1:jbee_pkg::CODE_W];
         merge_bits = tbl_rd_data[jbee_pkg::CODE_W-1:0];
      end
      len_mask  = (17'd1 << merge_len) - 17'd1;
      merged    = (acc_ff << merge_len) | ACC_W'(merge_bits & len_mask[jbee_pkg::CODE_W-1:0]);
      cnt_merge = CNT_W'(cnt_ff + CNT_W'(merge_len));
   end

   always_comb begin
      have_byte = stuff_ff || (cnt_ff >= CNT_W'(8));
      extracted = 8'(acc_ff >> (cnt_ff - CNT_W'(8)));
      byte_val  = stuff_ff ? jbee_pkg::STUFF_BYTE : extracted;
      drop      = bytes_ff == RES_W'(jbee_pkg::MAX_RESULTS);
      emit_go   = drop || !hold_valid_ff || push_space;
      len_sat   = (req.code_length > jbee_pkg::LEN_W'(MAX_CODE_LEN))
                  ? jbee_pkg::LEN_W'(MAX_CODE_LEN) : req.code_length;
   end

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      zr_in         = zr_ff;
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      stuff_in      = stuff_ff;
      zrl_cnt_in    = zrl_cnt_ff;
      main_pend_in  = main_pend_ff;
      vli_pend_in   = vli_pend_ff;
      eob_pend_in   = eob_pend_ff;
      main_idx_in   = main_idx_ff;
      vli_bits_in   = vli_bits_ff;
      vli_size_in   = vli_size_ff;
      rd_addr_in    = rd_addr_ff;
      bytes_in      = bytes_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;

      tbl.wr_en   = 1'b0;
      tbl.wr_addr = req.table_index;
      tbl.wr_data = {len_sat, req.code_bits};
      tbl.rd_en   = 1'b0;
      tbl.rd_addr = rd_addr_ff;
      push        = '0;

      case (state_ff)
         jbee_pkg::S_IDLE: begin
            if (accept) begin
               bytes_in = '0;
               case (req.req_type)
                  jbee_pkg::REQ_TABLE: begin
                     tbl.wr_en = req.table_index < AW'(jbee_pkg::TABLE_ENTRIES);
                  end
                  jbee_pkg::REQ_FLUSH: begin
                     if (cnt_ff != '0) begin
                        acc_in   = acc_ff << (CNT_W'(8) - cnt_ff);
                        cnt_in   = CNT_W'(8);
                        state_in = jbee_pkg::S_DRAIN;
                     end
                  end
                  jbee_pkg::REQ_COEF: begin
                     vli_bits_in  = vli12[jbee_pkg::VLI_W-1:0];
                     vli_size_in  = sz;
                     zrl_cnt_in   = 2'b00;
                     main_pend_in = 1'b0;
                     vli_pend_in  = 1'b0;
                     eob_pend_in  = 1'b0;
                     if (pos_ff == '0) begin
                        main_idx_in  = AW'(sz);
                        main_pend_in = 1'b1;
                        vli_pend_in  = 1'b1;
                        zr_in        = '0;
                     end else if (coef == '0) begin
                        zr_in = zr_inc;
                        if (last_pos) begin
                           eob_pend_in = zr_inc != '0;
                           zr_in       = '0;
                        end
                     end else begin
                        // Runs above fifteen go out as one ZRL for each sixteen zeros.
                        zrl_cnt_in   = zr_ff[5:4];
                        main_idx_in  = ac_idx;
                        main_pend_in = 1'b1;
                        vli_pend_in  = 1'b1;
                        zr_in        = '0;
                     end
                     pos_in = last_pos ? 6'd0 : 6'(pos_ff + 6'd1);
                     if ((pos_ff == '0) || (coef != '0) || last_pos) begin
                        state_in = jbee_pkg::S_DRAIN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         jbee_pkg::S_READ: begin
            tbl.rd_en = 1'b1;
            state_in  = jbee_pkg::S_CODE;
         end

         jbee_pkg::S_CODE, jbee_pkg::S_VLI: begin
            acc_in   = merged;
            cnt_in   = cnt_merge;
            state_in = jbee_pkg::S_DRAIN;
         end

         jbee_pkg::S_DRAIN: begin
            if (have_byte) begin
               if (emit_go) begin
                  if (!drop) begin
                     // The byte held back goes out now that it is known not to be the last.
                     push.valid    = hold_valid_ff;
                     push.data     = hold_ff;
                     push.last     = 1'b0;
                     hold_in       = byte_val;
                     hold_valid_in = 1'b1;
                     bytes_in      = RES_W'(bytes_ff + 1'b1);
                  end
                  if (stuff_ff) begin
                     stuff_in = 1'b0;
                  end else begin
                     cnt_in   = CNT_W'(cnt_ff - CNT_W'(8));
                     stuff_in = extracted == jbee_pkg::BYTE_ALL_ONES;
                  end
               end
            end else if (zrl_cnt_ff != 2'b00) begin
               rd_addr_in = AW'(jbee_pkg::ZRL_INDEX);
               zrl_cnt_in = 2'(zrl_cnt_ff - 2'b01);
               state_in   = jbee_pkg::S_READ;
            end else if (main_pend_ff) begin
               rd_addr_in   = main_idx_ff;
               main_pend_in = 1'b0;
               state_in     = jbee_pkg::S_READ;
            end else if (vli_pend_ff) begin
               vli_pend_in = 1'b0;
               state_in    = jbee_pkg::S_VLI;
            end else if (eob_pend_ff) begin
               rd_addr_in  = AW'(jbee_pkg::EOB_INDEX);
               eob_pend_in = 1'b0;
               state_in    = jbee_pkg::S_READ;
            end else begin
               state_in = jbee_pkg::S_END;
            end
         end

         jbee_pkg::S_END: begin
            if (!hold_valid_ff) begin
               state_in = jbee_pkg::S_IDLE;
            end else if (push_space) begin
               push.valid    = 1'b1;
               push.data     = hold_ff;
               push.last     = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = jbee_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = jbee_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= jbee_pkg::S_IDLE;
         pos_ff        <= '0;
         zr_ff         <= '0;
         cnt_ff        <= '0;
         stuff_ff      <= 1'b0;
         zrl_cnt_ff    <= '0;
         main_pend_ff  <= 1'b0;
         vli_pend_ff   <= 1'b0;
         eob_pend_ff   <= 1'b0;
         bytes_ff      <= '0;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         zr_ff         <= zr_in;
         cnt_ff        <= cnt_in;
         stuff_ff      <= stuff_in;
         zrl_cnt_ff    <= zrl_cnt_in;
         main_pend_ff  <= main_pend_in;
         vli_pend_ff   <= vli_pend_in;
         eob_pend_ff   <= eob_pend_in;
         bytes_ff      <= bytes_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      main_idx_ff <= main_idx_in;
      vli_bits_ff <= vli_bits_in;
      vli_size_ff <= vli_size_in;
      rd_addr_ff  <= rd_addr_in;
      hold_ff     <= hold_in;
   end

   // Between transactions fewer than eight bits may be pending.
   assert property (@(posedge clock) disable iff (reset)
                    state_ff == jbee_pkg::S_IDLE |-> cnt_ff < CNT_W'(8))
      else $error("whole byte left pending between transactions");

   // The held-back byte must have been released before a new transaction starts.
   assert property (@(posedge clock) disable iff (reset)
                    state_ff == jbee_pkg::S_IDLE |-> !hold_valid_ff)
      else $error("held byte not released at end of transaction");

   assert property (@(posedge clock) disable iff (reset)
                    bytes_ff <= RES_W'(jbee_pkg::MAX_RESULTS))
      else $error("byte count beyond result limit");

   // Table data is consumed in the cycle after the read.
   assert property (@(posedge clock) disable iff (reset)
                    tbl.rd_en |=> state_ff == jbee_pkg::S_CODE)
      else $error("table read not followed by code merge");

   assert property (@(posedge clock) disable iff (reset)
                    push.valid |-> push_space)
      else $error("byte pushed into full output queue");

endmodule

// File: src/jpeg_block_entropy_encoder_unit.sv
// Top level of the JPEG baseline block entropy encoder.
// Takes one request transaction at a time: a coefficient (zigzag order, block position
// tracked internally), a Huffman table write or a flush. Table writes, zero AC
// coefficients inside a block and flushes with nothing pending finish in the idle state.
// A DC or nonzero AC coefficient is coded as its codeword and then its value bits, with
// any ZRL codewords in front of it. A zero coefficient that closes a block codes the EOB
// codeword. Every codeword costs a read of the Huffman table RAM followed by a merge into
// the bit packer, and bytes (stuffed zero bytes included) leave the packer one per cycle
// while the output queue has space. A flush with pending bits pads them with zero bits to a
// whole byte. Coded bytes wait in a four-entry output queue behind one held-back byte, so
// a short stall on the response side does not hold up the next request; a longer one
// fills the queue and the encoder waits, with its input stalled, until space frees up.
// The last byte of each request carries last_of_run. The table has no reset and needs no
// clearing pass, but every entry that a coefficient uses must be written first.
module jpeg_block_entropy_encoder_unit #(
   parameter int MAX_CODE_LEN = 16
) (
   input logic        clock,
   input logic        reset,
   jbee_req_if.sink   req_ch,
   jbee_rsp_if.source rsp_ch
);

   jbee_pkg::tbl_access_type        tbl;
   logic [jbee_pkg::TABLE_W-1:0]    tbl_rd_data;
   jbee_pkg::byte_push_type         push;
   logic                            push_space;

   jbee_engine #(
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .tbl         (tbl),
      .tbl_rd_data (tbl_rd_data),
      .push        (push),
      .push_space  (push_space)
   );

   jbee_ram #(
      .WIDTH (jbee_pkg::TABLE_W),
      .DEPTH (jbee_pkg::TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl.wr_en),
      .wr_addr (tbl.wr_addr),
      .wr_data (tbl.wr_data),
      .rd_en   (tbl.rd_en),
      .rd_addr (tbl.rd_addr),
      .rd_data (tbl_rd_data)
   );

   jbee_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_space (push_space),
      .rsp        (rsp_ch)
   );

endmodule
